### src/pptp_call_id_nat_tracker_defines.svh
// Assertion macros for the PPTP call-ID NAT tracker.
`ifndef PPTP_CALL_ID_NAT_TRACKER_DEFINES_SVH
`define PPTP_CALL_ID_NAT_TRACKER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PCNT_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcnt: implication failed");

// Next-cycle implication, checked out of reset.
`define PCNT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcnt: next-cycle implication failed");

`endif

### src/pcnt_pkg.sv
// Types, constants and checksum helper for the PPTP call-ID NAT tracker.
`timescale 1ns / 1ps

package pcnt_pkg;

    localparam logic [31:0] MAGIC_COOKIE     = 32'h1A2B_3C4D;
    localparam logic [15:0] MSG_CONTROL      = 16'd1;
    localparam logic [15:0] CT_OUT_REQUEST   = 16'd7;
    localparam logic [15:0] CT_OUT_REPLY     = 16'd8;
    localparam logic [15:0] CT_IN_REPLY      = 16'd10;
    localparam logic [15:0] CT_CLEAR_REQUEST = 16'd12;
    localparam logic [15:0] CT_DISCONNECT    = 16'd13;
    localparam logic [15:0] CT_WAN_ERROR     = 16'd14;

    typedef enum logic [2:0] {
        ST_OK,
        ST_BAD_COOKIE,
        ST_REQ_REFUSED,
        ST_REPLY_REFUSED,
        ST_MAP_FAILED,
        ST_NO_MAPPING
    } pcnt_status_t;

    typedef struct packed {
        logic        direction;
        logic [15:0] msg_type;
        logic [31:0] magic_cookie;
        logic [15:0] control_type;
        logic [15:0] call_id;
        logic [15:0] peer_id;
        logic [15:0] tcp_checksum;
        logic        children_present;
        logic        map_ok;
        logic [15:0] mapped_call_id;
    } pcnt_hdr_t;

    typedef struct packed {
        pcnt_status_t status;
        logic [15:0]  new_call_id;
        logic [15:0]  new_peer_id;
        logic [15:0]  new_checksum;
        logic         rewritten;
        logic         map_requested;
        logic         open_pinholes;
        logic         release_map;
        logic         close_children;
    } pcnt_res_t;

    typedef struct packed {
        logic        request_seen;
        logic        reply_seen;
        logic        call_ended;
        logic        request_dir;
        logic        mapping_held;
        logic [15:0] inside_call_id;
        logic [15:0] outside_call_id;
        logic [15:0] server_call_id;
    } pcnt_state_t;

    // Incremental one's complement update: ~(~hc + ~old + new).
    function automatic logic [15:0] csum_fix(input logic [15:0] hc,
                                             input logic [15:0] oldv,
                                             input logic [15:0] newv);
        logic [17:0] s;
        logic [16:0] s1;
        logic [15:0] s2;
        s  = {2'b00, ~hc} + {2'b00, ~oldv} + {2'b00, newv};
        s1 = {1'b0, s[15:0]} + {15'd0, s[17:16]};
        s2 = s1[15:0] + {15'd0, s1[16]};
        return ~s2;
    endfunction

endpackage

### src/pptp_call_id_nat_tracker.sv
// Top level of the PPTP call-ID NAT tracker: call state and result register.
`timescale 1ns / 1ps

// PPTP call-ID tracker for one control session through a carrier-grade NAT.
// One parsed PPTP header request is taken per clock; its result comes out of
// a single result register in the next cycle. Throughput is one header per
// cycle while not stalled. The whole per-header job (cookie check, outgoing
// call request/reply/clear bookkeeping, call-ID rewrite and the incremental
// TCP checksum fixup) is one combinational pass from the accepted header and
// the current call state into the call state and result registers. A header
// is taken whenever the result register is empty or its result leaves in
// the same cycle; hdr_stall is high only while a finished result is held up
// by res_stall. Non-control messages pass through untouched with status ok.
// The mapping grant (map_ok, mapped_call_id) is supplied with each header;
// the result flags ask the surrounding logic to take or release a mapping,
// open the GRE pinhole pair or time out child sessions.

`include "pptp_call_id_nat_tracker_defines.svh"

module pptp_call_id_nat_tracker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                hdr_valid,
    output logic                hdr_stall,
    input  pcnt_pkg::pcnt_hdr_t hdr,
    output logic                res_valid,
    input  logic                res_stall,
    output pcnt_pkg::pcnt_res_t res
);
    import pcnt_pkg::*;

    pcnt_state_t state_reg;
    pcnt_state_t state_next;
    pcnt_res_t   step_res;
    pcnt_res_t   res_reg;
    logic        res_valid_reg;
    logic        res_valid_next;
    logic        hdr_accept;
    logic        res_err;
    logic        res_flagged;

    // Result register can take a new request unless it holds one that stalls.
    assign hdr_stall  = res_valid_reg && res_stall;
    assign hdr_accept = hdr_valid && !hdr_stall;

    pcnt_step u_step (
        .hdr (hdr),
        .cur (state_reg),
        .nxt (state_next),
        .res (step_res)
    );

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (hdr_accept)
            res_valid_next = 1'b1;
        else if (!res_stall)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (hdr_accept)
                state_reg <= state_next;
        end
    end

    // Payload register: no reset needed.
    always_ff @(posedge clk)
    begin
        if (hdr_accept)
            res_reg <= step_res;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign res_err     = res_valid_reg && (res_reg.status != ST_OK);
    assign res_flagged = res_valid_reg && (res_reg.open_pinholes || res_reg.release_map);

    // Error results never carry a rewrite.
    `PCNT_ASSERT_IMPLY(a_err_no_rewrite, res_err, !res_reg.rewritten)
    // Pinholes open and mapping release only on a clean result.
    `PCNT_ASSERT_IMPLY(a_flags_ok, res_flagged, res_reg.status == ST_OK)
    // Every accepted request produces a result next cycle.
    `PCNT_ASSERT_NEXT(a_accept_result, hdr_accept, res_valid_reg)
    // Call state changes only on an accepted request.
    `PCNT_ASSERT_NEXT(a_state_hold, !hdr_accept, $stable(state_reg))

endmodule

### src/pcnt_step.sv
// Per-header call state update and call-ID/checksum rewrite (combinational).
`timescale 1ns / 1ps

module pcnt_step (
    input  pcnt_pkg::pcnt_hdr_t   hdr,
    input  pcnt_pkg::pcnt_state_t cur,
    output pcnt_pkg::pcnt_state_t nxt,
    output pcnt_pkg::pcnt_res_t   res
);
    import pcnt_pkg::*;

    logic is_ctrl;
    logic cookie_ok;
    logic has_cid;
    logic has_pcid;
    logic is_close;

    assign is_ctrl   = (hdr.msg_type == MSG_CONTROL);
    assign cookie_ok = (hdr.magic_cookie == MAGIC_COOKIE);
    assign has_cid   = (hdr.control_type >= CT_OUT_REQUEST) &&
                       (hdr.control_type <= CT_WAN_ERROR);
    assign has_pcid  = (hdr.control_type == CT_OUT_REPLY) ||
                       (hdr.control_type == CT_IN_REPLY);
    assign is_close  = ((hdr.control_type == CT_CLEAR_REQUEST) ||
                        (hdr.control_type == CT_DISCONNECT)) &&
                       (hdr.call_id != 16'd0);

    always_comb
    begin
        pcnt_status_t st;
        st  = ST_OK;
        nxt = cur;
        res = '{status: ST_OK, new_call_id: hdr.call_id,
                new_peer_id: hdr.peer_id, new_checksum: hdr.tcp_checksum,
                rewritten: 1'b0, map_requested: 1'b0, open_pinholes: 1'b0,
                release_map: 1'b0, close_children: 1'b0};

        if (is_ctrl && !cookie_ok)
        begin
            st = ST_BAD_COOKIE;
        end
        else if (is_ctrl)
        begin
            if (hdr.control_type == CT_OUT_REQUEST)
            begin
                if (cur.request_seen)
                begin
                    if (cur.call_ended || !hdr.children_present)
                    begin
                        nxt.call_ended      = 1'b0;
                        nxt.request_seen    = 1'b0;
                        nxt.reply_seen      = 1'b0;
                        nxt.inside_call_id  = '0;
                        nxt.outside_call_id = '0;
                        nxt.server_call_id  = '0;
                    end
                    else
                    begin
                        st = ST_REQ_REFUSED;
                    end
                end
                if (st == ST_OK)
                begin
                    nxt.request_dir  = hdr.direction;
                    nxt.request_seen = 1'b1;
                    if (!hdr.direction)
                    begin
                        nxt.inside_call_id = hdr.call_id;
                        if (hdr.map_ok)
                        begin
                            res.release_map     = cur.mapping_held;
                            nxt.mapping_held    = 1'b1;
                            nxt.outside_call_id = hdr.mapped_call_id;
                            res.map_requested   = 1'b1;
                        end
                        else
                        begin
                            st = ST_MAP_FAILED;
                        end
                    end
                    else
                    begin
                        nxt.server_call_id = hdr.call_id;
                    end
                end
            end
            else if (hdr.control_type == CT_OUT_REPLY)
            begin
                if (!cur.request_seen || cur.reply_seen ||
                    (hdr.direction == cur.request_dir))
                begin
                    st = ST_REPLY_REFUSED;
                end
                else
                begin
                    nxt.reply_seen = 1'b1;
                    if (!hdr.direction)
                    begin
                        nxt.inside_call_id = hdr.call_id;
                        if (hdr.map_ok)
                        begin
                            res.release_map     = cur.mapping_held;
                            nxt.mapping_held    = 1'b1;
                            nxt.outside_call_id = hdr.mapped_call_id;
                            res.map_requested   = 1'b1;
                        end
                        else
                        begin
                            st = ST_MAP_FAILED;
                        end
                    end
                    else
                    begin
                        nxt.server_call_id = hdr.call_id;
                    end
                    if (st == ST_OK)
                    begin
                        if (!nxt.mapping_held)
                        begin
                            st = ST_NO_MAPPING;
                        end
                        else
                        begin
                            res.open_pinholes = 1'b1;
                            nxt.mapping_held  = 1'b0;
                        end
                    end
                end
            end
            else
            begin
                if (is_close)
                begin
                    res.release_map    = cur.mapping_held;
                    nxt.mapping_held   = 1'b0;
                    res.close_children = 1'b1;
                    nxt.call_ended     = 1'b1;
                end
                if (has_cid)
                begin
                    if (!hdr.direction && (cur.inside_call_id == 16'd0))
                        nxt.inside_call_id = hdr.call_id;
                    if (hdr.direction && (cur.server_call_id == 16'd0))
                        nxt.server_call_id = hdr.call_id;
                end
            end

            // Rewrite uses the state as left by this header.
            if ((st == ST_OK) && (nxt.outside_call_id != 16'd0))
            begin
                if (!hdr.direction && has_cid)
                begin
                    res.new_call_id  = nxt.outside_call_id;
                    res.new_checksum = csum_fix(hdr.tcp_checksum, hdr.call_id,
                                                nxt.outside_call_id);
                    res.rewritten    = 1'b1;
                end
                else if (hdr.direction && has_pcid)
                begin
                    res.new_peer_id  = nxt.inside_call_id;
                    res.new_checksum = csum_fix(hdr.tcp_checksum, hdr.peer_id,
                                                nxt.inside_call_id);
                    res.rewritten    = 1'b1;
                end
            end
        end
        res.status = st;
    end

endmodule
